>>> sv/shifted_laplacian_stencil_defines.svh
// Assertion macros used by the stencil front end.
`ifndef SHIFTED_LAPLACIAN_STENCIL_DEFINES_SVH
`define SHIFTED_LAPLACIAN_STENCIL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SLS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SLS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/sls_pkg.sv
// Types and constants shared by the shifted Laplacian stencil.
`timescale 1ns / 1ps
package sls_pkg;

   localparam int SAMPLE_W    = 32;
   localparam int EPS_W       = 16;
   localparam int GRID_W      = 11;
   localparam int OUT_W       = 36;
   localparam int POS_W       = 10;
   localparam int PROD_W      = SAMPLE_W + EPS_W;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QLEVEL_W    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_SIZE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EPS_WEIGHT = 1'd1;

   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic [GRID_W-1:0] GRID_RESET = 11'd16;
   localparam logic [EPS_W-1:0]  EPS_RESET  = 16'd655;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [OUT_W-1:0]    stencil_type;
   typedef logic [POS_W-1:0]           pos_type;

   // One result in flight; absent neighbors already replaced by the center.
   typedef struct packed {
      logic signed [PROD_W-1:0] product;
      sample_type               center;
      sample_type               up_nb;
      sample_type               down_nb;
      sample_type               left_nb;
      sample_type               right_nb;
      pos_type                  row;
      pos_type                  col;
      logic                     last;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_slot_type;

endpackage

>>> sv/sls_ifs.sv
// Valid/ready channel interfaces: request, response and register write.
`timescale 1ns / 1ps
interface sls_req_if;
   import sls_pkg::*;
   logic       valid;
   logic       ready;
   logic       operation;
   sample_type sample;
   modport source (output valid, operation, sample, input ready);
   modport sink   (input valid, operation, sample, output ready);
endinterface

interface sls_rsp_if;
   import sls_pkg::*;
   logic        valid;
   logic        ready;
   stencil_type stencil_value;
   pos_type     row_index;
   pos_type     column_index;
   logic        last_in_frame;
   modport source (output valid, stencil_value, row_index, column_index, last_in_frame,
                   input ready);
   modport sink   (input valid, stencil_value, row_index, column_index, last_in_frame,
                   output ready);
endinterface

interface sls_csr_if;
   import sls_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/sls_front.sv
// Front end: registers, request classification, line store and neighbor window.
`timescale 1ns / 1ps
`include "shifted_laplacian_stencil_defines.svh"
module sls_front #(
   parameter int MAX_GRID = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   sls_req_if.sink                       req_bus,
   sls_csr_if.sink                       csr_bus,
   input  logic [sls_pkg::QLEVEL_W-1:0]  q_level,
   output sls_pkg::queue_slot_type       q_push
);
   import sls_pkg::*;

   localparam int IDX_W     = $clog2(MAX_GRID);
   localparam int N_W       = IDX_W + 1;
   localparam int MEM_DEPTH = 2 * MAX_GRID;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   function automatic logic [ADDR_W-1:0] line_addr(input logic slot,
                                                   input logic [IDX_W-1:0] col);
      line_addr = slot ? ADDR_W'(MAX_GRID) + ADDR_W'(col) : ADDR_W'(col);
   endfunction

   // configuration
   logic [GRID_W-1:0] grid_ff, grid_in;
   logic [EPS_W-1:0]  eps_ff, eps_in;
   logic [N_W-1:0]    n_eff;

   // raster position and drain state
   logic [IDX_W-1:0] row_ff, row_in, col_ff, col_in, dcol_ff, dcol_in;
   logic [N_W-1:0]   pend_ff, pend_in;
   sample_type       first_ff, first_in;

   // classification
   logic             accept, is_push, push_ok, drain_ok, res_valid;
   logic [IDX_W-1:0] res_row, res_col;
   logic [N_W-1:0]   col_p1, row_p1, res_col_p1, n_m1;
   logic             has_right;
   logic [ADDR_W-1:0] right_addr, up_addr, wr_addr;

   // line store
   sample_type line_mem [MEM_DEPTH];
   sample_type rd_right_ff, rd_up_ff;

   // stage one
   logic             s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0] s1_row_ff, s1_col_ff;
   logic             s1_last_ff, s1_up_ff, s1_down_ff, s1_left_ff, s1_right_ff;
   sample_type       s1_sample_ff, s1_first_ff;

   // window over the row being finished
   sample_type win_center_ff, win_right_ff;
   sample_type center;
   logic signed [PROD_W:0] prod_full;
   logic [QLEVEL_W:0] in_flight;

   assign csr_bus.ready = 1'b1;
   assign in_flight     = (QLEVEL_W + 1)'(q_level) + (QLEVEL_W + 1)'(s1_valid_ff);
   assign req_bus.ready = in_flight < (QLEVEL_W + 1)'(QUEUE_DEPTH);
   assign accept        = req_bus.valid & req_bus.ready;

   always_comb begin
      if (grid_ff < GRID_W'(2)) begin
         n_eff = N_W'(2);
      end else if (int'(grid_ff) > MAX_GRID) begin
         n_eff = N_W'(MAX_GRID);
      end else begin
         n_eff = N_W'(grid_ff);
      end
   end

   always_comb begin
      is_push    = req_bus.operation == OP_PUSH;
      push_ok    = accept && is_push && (pend_ff == '0);
      drain_ok   = accept && !is_push && (pend_ff != '0);
      res_valid  = (push_ok && (row_ff != '0)) || drain_ok;
      n_m1       = n_eff - N_W'(1);
      res_row    = is_push ? row_ff - IDX_W'(1) : n_m1[IDX_W-1:0];
      res_col    = is_push ? col_ff : dcol_ff;
      res_col_p1 = {1'b0, res_col} + N_W'(1);
      has_right  = res_col_p1 < n_eff;
      right_addr = line_addr(res_row[0], has_right ? res_col_p1[IDX_W-1:0] : res_col);
      up_addr    = line_addr(~res_row[0], res_col);
      wr_addr    = line_addr(row_ff[0], col_ff);
      col_p1     = {1'b0, col_ff} + N_W'(1);
      row_p1     = {1'b0, row_ff} + N_W'(1);
   end

   always_comb begin
      grid_in  = grid_ff;
      eps_in   = eps_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      pend_in  = pend_ff;
      dcol_in  = dcol_ff;
      first_in = first_ff;
      if (push_ok) begin
         if (col_ff == '0) begin
            first_in = req_bus.sample;
         end
         if (col_p1 >= n_eff) begin
            col_in = '0;
            if (row_p1 >= n_eff) begin
               row_in  = '0;
               pend_in = n_eff;
               dcol_in = '0;
            end else begin
               row_in = row_p1[IDX_W-1:0];
            end
         end else begin
            col_in = col_p1[IDX_W-1:0];
         end
      end else if (drain_ok) begin
         pend_in = pend_ff - N_W'(1);
         dcol_in = (pend_ff == N_W'(1)) ? '0 : dcol_ff + IDX_W'(1);
      end
      // a size write restarts the frame
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_GRID_SIZE: begin
               grid_in = csr_bus.data[GRID_W-1:0];
               row_in  = '0;
               col_in  = '0;
               pend_in = '0;
               dcol_in = '0;
            end
            CSR_EPS_WEIGHT: begin
               eps_in = csr_bus.data[EPS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign s1_valid_in = res_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff     <= GRID_RESET;
         eps_ff      <= EPS_RESET;
         row_ff      <= '0;
         col_ff      <= '0;
         pend_ff     <= '0;
         dcol_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         grid_ff     <= grid_in;
         eps_ff      <= eps_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         pend_ff     <= pend_in;
         dcol_ff     <= dcol_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // line store: two registered reads, one write; reads see the old contents
   always_ff @(posedge clock) begin
      rd_right_ff <= line_mem[right_addr];
      rd_up_ff    <= line_mem[up_addr];
      if (push_ok) begin
         line_mem[wr_addr] <= req_bus.sample;
      end
   end

   always_ff @(posedge clock) begin
      first_ff     <= first_in;
      s1_row_ff    <= res_row;
      s1_col_ff    <= res_col;
      s1_last_ff   <= drain_ok && (pend_ff == N_W'(1));
      s1_up_ff     <= res_row != '0;
      s1_down_ff   <= is_push;
      s1_left_ff   <= res_col != '0;
      s1_right_ff  <= has_right;
      s1_sample_ff <= req_bus.sample;
      s1_first_ff  <= first_ff;
      if (s1_valid_ff) begin
         win_center_ff <= center;
         win_right_ff  <= rd_right_ff;
      end
   end

   // center comes from the previous result's right neighbor, or the column-0 copy
   always_comb begin
      center    = (s1_col_ff == '0) ? s1_first_ff : win_right_ff;
      prod_full = (PROD_W + 1)'(center) * (PROD_W + 1)'($signed({1'b0, eps_ff}));
      q_push.valid          = s1_valid_ff;
      q_push.entry.product  = prod_full[PROD_W-1:0];
      q_push.entry.center   = center;
      q_push.entry.up_nb    = s1_up_ff    ? rd_up_ff      : center;
      q_push.entry.down_nb  = s1_down_ff  ? s1_sample_ff  : center;
      q_push.entry.left_nb  = s1_left_ff  ? win_center_ff : center;
      q_push.entry.right_nb = s1_right_ff ? rd_right_ff   : center;
      q_push.entry.row      = POS_W'(s1_row_ff);
      q_push.entry.col      = POS_W'(s1_col_ff);
      q_push.entry.last     = s1_last_ff;
   end

   `SLS_ASSERT_NOW(a_drain_at_origin, clock, reset, pend_ff != '0, (row_ff == '0) && (col_ff == '0), "pushes advanced during drain")
   `SLS_ASSERT_NOW(a_drain_count, clock, reset, pend_ff != '0, (N_W'({1'b0, dcol_ff}) + pend_ff) == n_eff, "drain column and pending count disagree")
   `SLS_ASSERT_NEXT(a_drop_silent, clock, reset, accept && is_push && (pend_ff != '0), !s1_valid_ff, "dropped request produced a result")

endmodule

>>> sv/sls_queue.sv
// Short result queue between front end and back end.
`timescale 1ns / 1ps
module sls_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  sls_pkg::queue_slot_type       q_push,
   input  logic                          q_pop,
   output sls_pkg::queue_slot_type       q_head,
   output logic [sls_pkg::QLEVEL_W-1:0]  q_level
);
   import sls_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   queue_entry_type   slots [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QLEVEL_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = q_push.valid ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QLEVEL_W'(q_push.valid) - QLEVEL_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.valid) begin
         slots[wr_ptr_ff] <= q_push.entry;
      end
   end

   assign q_head.valid = count_ff != '0;
   assign q_head.entry = slots[rd_ptr_ff];
   assign q_level      = count_ff;

endmodule

>>> sv/sls_back.sv
// Back end: eps shift, neighbor differences, saturation and response register.
`timescale 1ns / 1ps
module sls_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sls_pkg::queue_slot_type  q_head,
   output logic                     q_pop,
   sls_rsp_if.source                rsp_bus
);
   import sls_pkg::*;

   localparam int SUM_W = PROD_W + 3;
   localparam logic signed [SUM_W-1:0] SAT_MAX = (SUM_W'(1) <<< (OUT_W - 1)) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] SAT_MIN = -(SUM_W'(1) <<< (OUT_W - 1));

   logic signed [SUM_W-1:0] shifted, sum;
   stencil_type             value;
   logic                    out_valid_ff, out_valid_in;
   stencil_type             value_ff;
   pos_type                 row_ff, col_ff;
   logic                    last_ff;

   always_comb begin
      // arithmetic shift floors toward minus infinity
      shifted = SUM_W'($signed(q_head.entry.product)) >>> FRAC_BITS;
      sum = shifted
          + (SUM_W'($signed(q_head.entry.center)) <<< 2)
          - SUM_W'($signed(q_head.entry.up_nb))
          - SUM_W'($signed(q_head.entry.down_nb))
          - SUM_W'($signed(q_head.entry.left_nb))
          - SUM_W'($signed(q_head.entry.right_nb));
      if (sum > SAT_MAX) begin
         value = OUT_W'(SAT_MAX);
      end else if (sum < SAT_MIN) begin
         value = OUT_W'(SAT_MIN);
      end else begin
         value = OUT_W'(sum);
      end
   end

   assign q_pop = q_head.valid && (!out_valid_ff || rsp_bus.ready);

   always_comb begin
      if (q_pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         value_ff <= value;
         row_ff   <= q_head.entry.row;
         col_ff   <= q_head.entry.col;
         last_ff  <= q_head.entry.last;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.stencil_value = value_ff;
   assign rsp_bus.row_index     = row_ff;
   assign rsp_bus.column_index  = col_ff;
   assign rsp_bus.last_in_frame = last_ff;

endmodule

>>> sv/shifted_laplacian_stencil.sv
// Top level of the streaming eps-shifted five-point Laplacian.
`timescale 1ns / 1ps
// Streams an n-by-n grid of signed Q16.16 samples in raster order (push requests) and
// returns, per grid point, floor(eps*x) plus the sum of (x - neighbor) over the up, down,
// left and right neighbors inside the grid (Neumann edges), saturated to signed 36 bits.
// The result for row r-1 leaves when the sample of row r, same column, is pushed, so the
// first row yields nothing; after the last sample of a frame, n drain requests release the
// last row, the final one marked last_in_frame. Pushes arriving while drains are still
// owed are dropped; drains with nothing owed are consumed silently. A grid_size write
// restarts the frame (values below 2 act as 2, above MAX_GRID as MAX_GRID); eps_weight is
// an unsigned Q0.16 fraction. The user must write registers only while the block is idle;
// the block itself does not enforce this. Rate: one request per clock, sustained while
// responses are taken; when rsp ready stays low, requests are held off once four results
// wait behind the held response. The line store has one write and two read ports, enough
// for one point per cycle. From request to response valid, a result passes the line store
// read, the window and eps multiply, then the queue and the final sum into the response
// register. The line store needs no clearing pass after reset.
module shifted_laplacian_stencil #(
   parameter int MAX_GRID  = 1024,
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   sls_req_if.sink     req_bus,
   sls_rsp_if.source   rsp_bus,
   sls_csr_if.sink     csr_bus
);
   import sls_pkg::*;

   queue_slot_type      q_push;   // front to queue
   queue_slot_type      q_head;   // queue to back
   logic                q_pop;
   logic [QLEVEL_W-1:0] q_level;  // front holds off requests when the queue may fill

   // front: classifies each request, keeps the line store and the neighbor window
   sls_front #(
      .MAX_GRID (MAX_GRID)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .csr_bus (csr_bus),
      .q_level (q_level),
      .q_push  (q_push)
   );

   // queue decouples the front from response backpressure
   sls_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_pop   (q_pop),
      .q_head  (q_head),
      .q_level (q_level)
   );

   // back: combines the terms and holds the response until taken
   sls_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule
